@@ rtl/core/via_sr_pkg.sv @@
// Shared types and constants of the VIA serial shift register.
package via_sr_pkg;

  // Shift mode codes (low three bits of the mode register)
  localparam logic [2:0] MODE_OFF       = 3'd0;
  localparam logic [2:0] MODE_IN_TIMER  = 3'd1;
  localparam logic [2:0] MODE_IN_CLOCK  = 3'd2;
  localparam logic [2:0] MODE_IN_EXT    = 3'd3;
  localparam logic [2:0] MODE_OUT_FREE  = 3'd4;
  localparam logic [2:0] MODE_OUT_TIMER = 3'd5;
  localparam logic [2:0] MODE_OUT_CLOCK = 3'd6;
  localparam logic [2:0] MODE_OUT_EXT   = 3'd7;

  // Word opcodes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Configuration register indexes
  localparam logic CFG_SHIFT_MODE  = 1'b0;
  localparam logic CFG_TIMER_LATCH = 1'b1;

  localparam logic [8:0] LATCH_MASK = 9'h0ff;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] write_data;
    logic       clock_edge_in;
    logic       data_line_in;
  } in_word_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       clock_line_out;
    logic       data_line_out;
    logic       irq_flag;
    logic       busy_res;
  } out_word_t;

  typedef struct packed {
    logic [7:0] shift_data;
    logic [2:0] bit_count;
    logic       active;
    logic       finish_wait;
    logic [8:0] divider_count;
    logic       clock_phase;
    logic       irq_pending;
    logic       clock_line_level;
    logic       data_line_level;
  } sr_state_t;

  function automatic logic drives_clock(input logic [2:0] mode);
    return (mode == MODE_IN_TIMER) || (mode == MODE_IN_CLOCK) || (mode == MODE_OUT_FREE) ||
           (mode == MODE_OUT_TIMER) || (mode == MODE_OUT_CLOCK);
  endfunction

  function automatic logic uses_timer(input logic [2:0] mode);
    return (mode == MODE_IN_TIMER) || (mode == MODE_OUT_FREE) || (mode == MODE_OUT_TIMER);
  endfunction

  function automatic logic [8:0] reload_value(input logic [7:0] latch);
    return ({1'b0, latch} & LATCH_MASK) + 9'd1;
  endfunction

endpackage

@@ rtl/core/via_sr_chan_if.sv @@
// Valid/ready channel carrying one word per handshake.
interface via_sr_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/core/via_sr_step.sv @@
// Next-state logic of the shift register for one word.
module via_sr_step (
  input  logic [2:0]           mode,
  input  logic [7:0]           latch,
  input  via_sr_pkg::in_word_t word,
  input  via_sr_pkg::sr_state_t cur,
  output via_sr_pkg::sr_state_t nxt
);
  import via_sr_pkg::*;

  always_comb begin
    logic       shift;
    logic       internal;
    logic       top_bit;
    logic [8:0] reload;
    nxt      = cur;
    shift    = 1'b0;
    internal = 1'b0;
    top_bit  = cur.shift_data[7];
    reload   = reload_value(latch);
    unique case (word.opcode)
      OP_WRITE, OP_READ: begin
        if (word.opcode == OP_WRITE) begin
          nxt.shift_data = word.write_data;
          if (mode[2]) begin
            nxt.data_line_level = word.write_data[7];
          end
        end
        nxt.bit_count     = '0;
        nxt.active        = (mode != MODE_OFF);
        nxt.finish_wait   = 1'b0;
        nxt.clock_phase   = 1'b1;
        nxt.irq_pending   = 1'b0;
        nxt.divider_count = uses_timer(mode) ? reload : '0;
        if (drives_clock(mode)) begin
          nxt.clock_line_level = 1'b1;
        end
      end
      OP_TICK: begin
        if (mode == MODE_OFF) begin
          nxt.irq_pending = 1'b0;
        end else begin
          if (uses_timer(mode)) begin
            internal = 1'b1;
            if (cur.active) begin
              if (cur.divider_count == '0) begin
                nxt.divider_count    = reload;
                nxt.clock_phase      = ~cur.clock_phase;
                nxt.clock_line_level = ~cur.clock_phase;
                shift                = cur.clock_phase;
              end else begin
                nxt.divider_count = cur.divider_count - 9'd1;
              end
            end
          end else if (mode == MODE_IN_CLOCK || mode == MODE_OUT_CLOCK) begin
            internal = 1'b1;
            if (cur.active) begin
              nxt.clock_phase      = ~cur.clock_phase;
              nxt.clock_line_level = ~cur.clock_phase;
              shift                = cur.clock_phase;
            end
          end else begin
            shift = word.clock_edge_in;
          end

          if (internal && cur.finish_wait && nxt.clock_phase) begin
            // extra half-cycle done: stop the transfer
            nxt.finish_wait = 1'b0;
            nxt.active      = 1'b0;
          end else if (shift) begin
            if (mode[2]) begin
              nxt.shift_data      = {cur.shift_data[6:0], top_bit};
              nxt.data_line_level = top_bit;
            end else begin
              nxt.shift_data = {cur.shift_data[6:0], word.data_line_in};
            end
            nxt.bit_count = cur.bit_count + 3'd1;
            if (cur.bit_count == 3'd7) begin
              if (mode != MODE_OUT_FREE) begin
                nxt.irq_pending = 1'b1;
              end
              if (mode == MODE_IN_TIMER || mode == MODE_IN_CLOCK ||
                  mode == MODE_OUT_TIMER || mode == MODE_OUT_CLOCK) begin
                nxt.finish_wait = 1'b1;
              end
            end
          end
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

@@ rtl/core/via_shift_register.sv @@
// Top level of the VIA serial shift register.
// Serial shift register of a 6522-style interface adapter. Each word on req is a tick,
// a data write or a data read; each produces exactly one word on rsp that shows the
// shift data, the driven clock and data lines, the interrupt flag and the busy flag
// after the word. A word goes through an input register, one pass of next-state logic
// and an output register; one word per cycle is taken, the rate set only by stalls on rsp.
// Configuration (cfg_index 0: shift mode, 1: low timer latch byte) goes through cfg_we;
// the user must write it only while no word is in flight; the block does not enforce it.
module via_shift_register (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  via_sr_chan_if.sink   req,
  via_sr_chan_if.source rsp
);
  import via_sr_pkg::*;

  // configuration registers
  logic [2:0] mode;
  logic [7:0] latch;

  // input stage
  logic     s1_valid;
  in_word_t s1_word;

  // architectural state
  sr_state_t state;
  sr_state_t state_next;

  // output stage
  logic      out_valid;
  out_word_t out_word;

  logic advance;

  // the input stage moves on whenever the output register is free or being drained
  assign advance   = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || advance;

  assign rsp.valid   = out_valid;
  assign rsp.payload = out_word;

  via_sr_step u_step (
    .mode  (mode),
    .latch (latch),
    .word  (s1_word),
    .cur   (state),
    .nxt   (state_next)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
    if (req.valid && req.ready) begin
      s1_word <= req.payload;
    end
  end

  // configuration and state; the user must write config only while idle (not enforced here)
  always_ff @(posedge clk) begin
    if (rst) begin
      mode                   <= MODE_OFF;
      latch                  <= '0;
      state.shift_data       <= '0;
      state.bit_count        <= '0;
      state.active           <= 1'b0;
      state.finish_wait      <= 1'b0;
      state.divider_count    <= '0;
      state.clock_phase      <= 1'b1;
      state.irq_pending      <= 1'b0;
      state.clock_line_level <= 1'b1;
      state.data_line_level  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SHIFT_MODE: begin
          mode                <= cfg_data[2:0];
          state.bit_count     <= '0;
          state.finish_wait   <= 1'b0;
          state.divider_count <= '0;
          state.clock_phase   <= 1'b1;
          state.active        <= (cfg_data[2:0] == MODE_IN_EXT) ||
                                 (cfg_data[2:0] == MODE_OUT_EXT);
          if (cfg_data[2:0] == MODE_OFF) begin
            state.irq_pending <= 1'b0;
          end
          if (drives_clock(cfg_data[2:0])) begin
            state.clock_line_level <= 1'b1;
          end
        end
        CFG_TIMER_LATCH: begin
          latch <= cfg_data;
        end
        default: begin
          latch <= latch;
        end
      endcase
    end else if (advance) begin
      state <= state_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_word.read_data      <= state_next.shift_data;
      out_word.clock_line_out <= state_next.clock_line_level;
      out_word.data_line_out  <= state_next.data_line_level;
      out_word.irq_flag       <= state_next.irq_pending;
      out_word.busy_res       <= state_next.active;
    end
  end

  // the finishing half-cycle is only armed together with the interrupt
  a_wait_has_irq: assert property (@(posedge clk) disable iff (rst)
    state.finish_wait |-> state.irq_pending)
    else $error("finish_wait set without irq_pending");

  // only stopping internal modes arm the finishing half-cycle
  a_wait_mode: assert property (@(posedge clk) disable iff (rst)
    state.finish_wait |-> (mode == MODE_IN_TIMER || mode == MODE_IN_CLOCK ||
                           mode == MODE_OUT_TIMER || mode == MODE_OUT_CLOCK))
    else $error("finish_wait set in a mode that never stops");

  // a word leaving the input stage always lands in the output register
  a_advance_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("word lost between input and output stage");

endmodule

@@ tb/tb_via_shift_register.sv @@
`timescale 1ns / 100ps
// Testbench for the VIA serial shift register: directed and random words, checked per word.
module tb_via_shift_register;
  import via_sr_pkg::*;

  // Opcode 3 has no meaning in the block; it must leave the state alone.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // Worst case is well under this; a hang trips it.
  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT = 19;
  localparam int HOLD_CYCLES = 150;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic       cfg_index;
  logic [7:0] cfg_data;

  via_sr_chan_if #(.payload_t(in_word_t))  req_if ();
  via_sr_chan_if #(.payload_t(out_word_t)) rsp_if ();

  via_shift_register DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .req      (req_if),
    .rsp      (rsp_if)
  );

  // Status words predicted for accepted requests, oldest first.
  out_word_t expected_status[$];
  int        errors = 0;
  int        cycles = 0;

  // Shared with the response-side process.
  bit steady = 1'b0;        // no idling on either side while set
  bit hold_request = 1'b0;  // ask the response side for one long stall

  // Predicted adapter state, kept in step with the block.
  logic [2:0] sr_mode;
  logic [7:0] sr_latch;
  logic [7:0] sr_data;
  logic [3:0] sr_bits;
  logic       sr_busy;
  logic       sr_finish_wait;
  logic [8:0] sr_divider;
  logic       sr_phase;
  logic       sr_irq;
  logic       sr_clk_line;
  logic       sr_data_line;

  // ---------------------------------------------------------------------------
  // Clock and cycle watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic void reset_adapter();
    sr_mode        = MODE_OFF;
    sr_latch       = 8'h00;
    sr_data        = 8'h00;
    sr_bits        = 4'd0;
    sr_busy        = 1'b0;
    sr_finish_wait = 1'b0;
    sr_divider     = 9'd0;
    sr_phase       = 1'b1;
    sr_irq         = 1'b0;
    sr_clk_line    = 1'b1;
    sr_data_line   = 1'b0;
  endfunction

  // Mode register write: the transfer bookkeeping starts over.
  function automatic void load_mode(logic [2:0] mode);
    sr_mode        = mode;
    sr_bits        = 4'd0;
    sr_finish_wait = 1'b0;
    sr_divider     = 9'd0;
    sr_phase       = 1'b1;
    sr_busy        = (mode == MODE_IN_EXT) || (mode == MODE_OUT_EXT);
    if (mode == MODE_OFF)
      sr_irq = 1'b0;
    if (mode == MODE_IN_TIMER || mode == MODE_IN_CLOCK || mode == MODE_OUT_FREE ||
        mode == MODE_OUT_TIMER || mode == MODE_OUT_CLOCK)
      sr_clk_line = 1'b1;
  endfunction

  // Works out the status word after one request word.
  function automatic out_word_t step_adapter(in_word_t w);
    out_word_t res;
    logic timer_mode;
    logic sysclk_mode;
    logic do_shift;
    logic top;
    timer_mode  = (sr_mode == MODE_IN_TIMER) || (sr_mode == MODE_OUT_FREE) ||
                  (sr_mode == MODE_OUT_TIMER);
    sysclk_mode = (sr_mode == MODE_IN_CLOCK) || (sr_mode == MODE_OUT_CLOCK);
    do_shift    = 1'b0;

    if (w.opcode == OP_WRITE || w.opcode == OP_READ) begin
      // Data access restarts the transfer and clears the interrupt
      if (w.opcode == OP_WRITE)
        sr_data = w.write_data;
      sr_bits        = 4'd0;
      sr_busy        = (sr_mode != MODE_OFF);
      sr_finish_wait = 1'b0;
      sr_phase       = 1'b1;
      sr_irq         = 1'b0;
      sr_divider     = timer_mode ? ({1'b0, sr_latch} + 9'd1) : 9'd0;
      if (timer_mode || sysclk_mode)
        sr_clk_line = 1'b1;
      if (w.opcode == OP_WRITE && sr_mode >= MODE_OUT_FREE)
        sr_data_line = sr_data[7];
    end else if (w.opcode == OP_TICK) begin
      if (sr_mode == MODE_OFF) begin
        sr_irq = 1'b0;
      end else begin
        if (timer_mode) begin
          if (sr_busy) begin
            if (sr_divider == 9'd0) begin
              sr_divider  = {1'b0, sr_latch} + 9'd1;
              sr_phase    = ~sr_phase;
              sr_clk_line = sr_phase;
              do_shift    = ~sr_phase;
            end else begin
              sr_divider = sr_divider - 9'd1;
            end
          end
        end else if (sysclk_mode) begin
          if (sr_busy) begin
            sr_phase    = ~sr_phase;
            sr_clk_line = sr_phase;
            do_shift    = ~sr_phase;
          end
        end else begin
          do_shift = w.clock_edge_in;
        end

        if ((timer_mode || sysclk_mode) && sr_finish_wait && sr_phase) begin
          // Extra half-cycle after the last bit is over: stop
          sr_finish_wait = 1'b0;
          sr_busy        = 1'b0;
        end else if (do_shift) begin
          if (sr_mode <= MODE_IN_EXT) begin
            sr_data = {sr_data[6:0], w.data_line_in};
          end else begin
            top          = sr_data[7];
            sr_data      = {sr_data[6:0], top};
            sr_data_line = top;
          end
          sr_bits = sr_bits + 4'd1;
          if (sr_bits >= 4'd8) begin
            sr_bits = 4'd0;
            if (sr_mode != MODE_OUT_FREE)
              sr_irq = 1'b1;
            if (sr_mode == MODE_IN_TIMER || sr_mode == MODE_IN_CLOCK ||
                sr_mode == MODE_OUT_TIMER || sr_mode == MODE_OUT_CLOCK)
              sr_finish_wait = 1'b1;
          end
        end
      end
    end
    // OP_UNUSED falls through with no change

    res.read_data      = sr_data;
    res.clock_line_out = sr_clk_line;
    res.data_line_out  = sr_data_line;
    res.irq_flag       = sr_irq;
    res.busy_res       = sr_busy;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Response side: random stalls, one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : response_side
    int hold_left;
    hold_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (steady) begin
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: each status word against the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : check_status
    out_word_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (expected_status.size() == 0) begin
        errors++;
        $display("%0t: unexpected status word, expected none, actual %p",
                 $time, rsp_if.payload);
      end else begin
        want = expected_status.pop_front();
        check_field("read_data", want.read_data, rsp_if.payload.read_data);
        check_field("clock_line_out", 8'(want.clock_line_out),
                    8'(rsp_if.payload.clock_line_out));
        check_field("data_line_out", 8'(want.data_line_out),
                    8'(rsp_if.payload.data_line_out));
        check_field("irq_flag", 8'(want.irq_flag), 8'(rsp_if.payload.irq_flag));
        check_field("busy_res", 8'(want.busy_res), 8'(rsp_if.payload.busy_res));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // Sends one word; valid stays high on return so back-to-back words need
  // no second assignment in the same step.
  task automatic send_word(logic [1:0] op, logic [7:0] wdata, logic edge_in, logic din);
    in_word_t w;
    w.opcode        = op;
    w.write_data    = wdata;
    w.clock_edge_in = edge_in;
    w.data_line_in  = din;
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= w;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    expected_status.push_back(step_adapter(w));
  endtask

  // Stop sending and let every outstanding word come back.
  task automatic drain();
    req_if.valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Latch first, then mode; cfg_we stays high across both writes.
  task automatic set_config(logic [2:0] mode, logic [7:0] latch);
    logic [7:0] mode_word;
    mode_word = {5'($urandom_range(31)), mode};  // upper bits are don't-care
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TIMER_LATCH;
    cfg_data  <= latch;
    @(posedge clk);
    cfg_index <= CFG_SHIFT_MODE;
    cfg_data  <= mode_word;
    @(posedge clk);
    cfg_we <= 1'b0;
    sr_latch = latch;
    load_mode(mode_word[2:0]);
  endtask

  // Transfer-shaped random traffic: a write, then mostly ticks with rare
  // reads, writes and junk opcodes. Stops after n meaningful words past the first write.
  task automatic run_transfer(int n);
    int  sent;
    int  pick;
    bit  ext_mode;
    logic edge_in;
    sent     = 0;
    ext_mode = (sr_mode == MODE_IN_EXT) || (sr_mode == MODE_OUT_EXT);
    send_word(OP_WRITE, 8'($urandom_range(255)), 1'($urandom_range(1)),
              1'($urandom_range(1)));
    while (sent < n) begin
      pick    = $urandom_range(99);
      edge_in = ext_mode ? ($urandom_range(99) < 40) : 1'($urandom_range(1));
      if (pick < 3) begin
        send_word(OP_WRITE, 8'($urandom_range(255)), edge_in, 1'($urandom_range(1)));
        sent++;
      end else if (pick < 6) begin
        send_word(OP_READ, 8'($urandom_range(255)), edge_in, 1'($urandom_range(1)));
        sent++;
      end else if (pick < 8) begin
        send_word(OP_UNUSED, 8'($urandom_range(255)), edge_in, 1'($urandom_range(1)));
      end else begin
        send_word(OP_TICK, 8'($urandom_range(255)), edge_in, 1'($urandom_range(1)));
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset state: data access and a tick with the shifter off, junk opcode.
  task automatic test_mode_off();
    send_word(OP_WRITE, 8'hFF, 1'b1, 1'b1);
    send_word(OP_READ, 8'h00, 1'b0, 1'b0);
    send_word(OP_UNUSED, 8'h5A, 1'b1, 1'b1);
    send_word(OP_TICK, 8'h00, 1'b1, 1'b1);
  endtask

  // External clock in: edges on the clock input fill a byte and raise the interrupt.
  task automatic test_external_input();
    set_config(MODE_IN_EXT, 8'hFF);
    send_word(OP_WRITE, 8'h00, 1'b0, 1'b0);
    for (int i = 0; i < 8; i++)
      send_word(OP_TICK, 8'h00, 1'b1, i[0]);
    send_word(OP_TICK, 8'h00, 1'b0, 1'b1);  // no edge, no shift
    send_word(OP_READ, 8'h00, 1'b0, 1'b0);
  endtask

  // External clock out: bit 7 on the data line, byte rotates, count wraps.
  task automatic test_external_output();
    set_config(MODE_OUT_EXT, 8'h00);
    send_word(OP_WRITE, 8'h81, 1'b0, 1'b0);
    for (int i = 0; i < 8; i++)
      send_word(OP_TICK, 8'h00, 1'b1, 1'b0);
    send_word(OP_UNUSED, 8'hFF, 1'b1, 1'b0);
  endtask

  // Every mode once, then a random one; one phase runs with no idling.
  task automatic test_random_modes();
    logic [2:0] mode;
    logic [7:0] latch;
    int pick;
    for (int p = 0; p < 9; p++) begin
      mode = (p < 8) ? p[2:0] : 3'($urandom_range(1, 7));
      pick = $urandom_range(99);
      if (p == 0)
        latch = 8'h00;
      else if (pick < 60)
        latch = 8'($urandom_range(2));
      else if (pick < 90)
        latch = 8'($urandom_range(3, 15));
      else
        latch = 8'($urandom_range(255));
      set_config(mode, latch);
      steady = (p == 5);
      run_transfer(50);
      steady = 1'b0;
    end
  endtask

  // Largest divider: an unbroken run of ticks, long enough for one reload and a shift.
  task automatic test_slow_divider();
    set_config(MODE_OUT_TIMER, 8'hFF);
    send_word(OP_WRITE, 8'hA5, 1'b0, 1'b0);
    repeat (260)
      send_word(OP_TICK, 8'h00, 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  // Response side stalls for a long stretch while requests keep coming.
  task automatic test_back_pressure();
    set_config(MODE_OUT_CLOCK, 8'h00);
    steady       = 1'b1;
    hold_request = 1'b1;
    run_transfer(60);
    steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_SHIFT_MODE;
    cfg_data       <= 8'h00;
    req_if.valid   <= 1'b0;
    req_if.payload <= '0;
    reset_adapter();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_mode_off();
    test_external_input();
    test_external_output();
    test_random_modes();
    test_slow_divider();
    test_back_pressure();

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/via_sr_pkg.sv
rtl/core/via_sr_chan_if.sv
rtl/core/via_sr_step.sv
rtl/core/via_shift_register.sv
tb/tb_via_shift_register.sv
